@@ rtl/core/sail_trim_motor_controller_top_defines.svh @@
// assertion macros for the sail trim motor controller
`ifndef SAIL_TRIM_MOTOR_CONTROLLER_TOP_DEFINES_SVH
`define SAIL_TRIM_MOTOR_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/stmc_pkg.sv @@
// types, constants and helpers shared by the sail trim motor controller
`default_nettype none

package stmc_pkg;

    localparam int ANGLE_WIDTH      = 9;
    localparam int SECONDS_WIDTH    = 12;
    localparam int ELAPSED_WIDTH    = 12;
    localparam int DEADBAND_WIDTH   = 8;
    localparam int MAX_TRIM_WIDTH   = 12;
    localparam int STALL_WIDTH      = 8;
    localparam int SAME_WIDTH       = 8;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = (ANGLE_WIDTH > MAX_TRIM_WIDTH) ? ANGLE_WIDTH
                                                                     : MAX_TRIM_WIDTH;

    localparam logic [SECONDS_WIDTH-1:0] SECONDS_MAX = {SECONDS_WIDTH{1'b1}};
    localparam logic [SAME_WIDTH-1:0]    SAME_MAX    = {SAME_WIDTH{1'b1}};
    localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = {ELAPSED_WIDTH{1'b1}};

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_DEADBAND  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_TRIM  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_STALL     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MIN_ANGLE = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_ANGLE = 3'd4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [1:0] DRIVE_STOP = 2'b00;
    localparam logic [1:0] DRIVE_DOWN = 2'b01;
    localparam logic [1:0] DRIVE_UP   = 2'b10;

    typedef struct packed {
        logic                   cmd;
        logic [ANGLE_WIDTH-1:0] target_angle;
        logic [ANGLE_WIDTH-1:0] position;
    } stmc_in_t;

    typedef struct packed {
        logic                     drive_down;
        logic                     drive_up;
        logic                     trimming;
        logic                     finished;
        logic                     timed_out;
        logic                     stalled;
        logic                     order_rejected;
        logic [ELAPSED_WIDTH-1:0] elapsed_seconds;
    } stmc_out_t;

    typedef struct packed {
        logic [DEADBAND_WIDTH-1:0] deadband;
        logic [MAX_TRIM_WIDTH-1:0] max_trim_seconds;
        logic [STALL_WIDTH-1:0]    stall_seconds;
        logic [ANGLE_WIDTH-1:0]    min_angle;
        logic [ANGLE_WIDTH-1:0]    max_angle;
    } stmc_cfg_t;

    typedef struct packed {
        logic                     active;
        logic [ANGLE_WIDTH-1:0]   goal;
        logic [ANGLE_WIDTH-1:0]   last_position;
        logic [SAME_WIDTH-1:0]    same_count;
        logic [SECONDS_WIDTH-1:0] seconds_count;
        logic                     timeout_flag;
        logic                     stall_flag;
        logic [1:0]               drive_bits;
    } stmc_state_t;

    localparam stmc_cfg_t CFG_RESET = '{
        deadband:         DEADBAND_WIDTH'(4),
        max_trim_seconds: MAX_TRIM_WIDTH'(900),
        stall_seconds:    STALL_WIDTH'(10),
        min_angle:        ANGLE_WIDTH'(0),
        max_angle:        ANGLE_WIDTH'(360)
    };

    function automatic logic [1:0] steer(input logic [ANGLE_WIDTH-1:0] pos,
                                         input logic [ANGLE_WIDTH-1:0] tgt);
        logic [1:0] d;
        if (pos > tgt)
        begin
            d = DRIVE_DOWN;
        end
        else if (pos < tgt)
        begin
            d = DRIVE_UP;
        end
        else
        begin
            d = DRIVE_STOP;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/stmc_cfg_regs.sv @@
// configuration register bank of the sail trim motor controller
`default_nettype none

module stmc_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [stmc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [stmc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output stmc_pkg::stmc_cfg_t                       cfg
);
    import stmc_pkg::*;

    stmc_cfg_t cfg_reg;
    stmc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_DEADBAND:  cfg_next.deadband         = cfg_data[DEADBAND_WIDTH-1:0];
                CFG_IDX_MAX_TRIM:  cfg_next.max_trim_seconds = cfg_data[MAX_TRIM_WIDTH-1:0];
                CFG_IDX_STALL:     cfg_next.stall_seconds    = cfg_data[STALL_WIDTH-1:0];
                CFG_IDX_MIN_ANGLE: cfg_next.min_angle        = cfg_data[ANGLE_WIDTH-1:0];
                CFG_IDX_MAX_ANGLE: cfg_next.max_angle        = cfg_data[ANGLE_WIDTH-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/stmc_step.sv @@
// next-state and result logic for one transaction of the trim controller
`default_nettype none

module stmc_step (
    input  wire stmc_pkg::stmc_cfg_t   cfg,
    input  wire stmc_pkg::stmc_state_t state,
    input  wire stmc_pkg::stmc_in_t    item,
    output stmc_pkg::stmc_state_t      state_next,
    output stmc_pkg::stmc_out_t        rsp
);
    import stmc_pkg::*;

    logic [ANGLE_WIDTH-1:0]   err;
    logic [SECONDS_WIDTH-1:0] seconds_inc;
    logic [SAME_WIDTH-1:0]    same_inc;
    logic                     out_of_range;
    logic                     rejected;
    logic                     ended;
    logic                     stop;

    assign err = (item.position > item.target_angle) ? item.position - item.target_angle
                                                     : item.target_angle - item.position;
    assign seconds_inc = (state.seconds_count == SECONDS_MAX)
                         ? state.seconds_count
                         : state.seconds_count + SECONDS_WIDTH'(1);
    assign same_inc = (state.same_count == SAME_MAX)
                      ? state.same_count
                      : state.same_count + SAME_WIDTH'(1);
    assign out_of_range = (item.target_angle < cfg.min_angle)
                       || (item.target_angle > cfg.max_angle);

    always_comb
    begin
        state_next = state;
        rejected   = 1'b0;
        ended      = 1'b0;
        stop       = 1'b0;
        if (item.cmd == CMD_START)
        begin
            if (out_of_range)
            begin
                rejected = 1'b1;
            end
            else
            begin
                state_next.timeout_flag  = 1'b0;
                state_next.stall_flag    = 1'b0;
                state_next.seconds_count = '0;
                state_next.same_count    = '0;
                state_next.last_position = item.position;
                state_next.goal          = item.target_angle;
                if (err > ANGLE_WIDTH'(cfg.deadband))
                begin
                    state_next.active     = 1'b1;
                    state_next.drive_bits = steer(item.position, item.target_angle);
                end
                else
                begin
                    state_next.active     = 1'b0;
                    state_next.drive_bits = DRIVE_STOP;
                end
            end
        end
        else if (state.active)
        begin
            state_next.seconds_count = seconds_inc;
            if (32'(seconds_inc) > 32'(cfg.max_trim_seconds))
            begin
                stop                    = 1'b1;
                state_next.timeout_flag = 1'b1;
            end
            if (item.position == state.last_position)
            begin
                state_next.same_count = same_inc;
                if (same_inc > SAME_WIDTH'(cfg.stall_seconds))
                begin
                    stop                  = 1'b1;
                    state_next.stall_flag = 1'b1;
                end
            end
            else
            begin
                state_next.last_position = item.position;
                state_next.same_count    = '0;
                state_next.stall_flag    = 1'b0;
            end
            if (item.position == state.goal)
            begin
                stop = 1'b1;
            end
            if (stop)
            begin
                state_next.active     = 1'b0;
                state_next.drive_bits = DRIVE_STOP;
                ended                 = 1'b1;
            end
            else
            begin
                state_next.drive_bits = steer(item.position, state.goal);
            end
        end
    end

    always_comb
    begin
        rsp.drive_down     = state_next.drive_bits[0];
        rsp.drive_up       = state_next.drive_bits[1];
        rsp.trimming       = state_next.active;
        rsp.finished       = ended;
        rsp.timed_out      = state_next.timeout_flag;
        rsp.stalled        = state_next.stall_flag;
        rsp.order_rejected = rejected;
        if (32'(state_next.seconds_count) > 32'(ELAPSED_MAX))
        begin
            rsp.elapsed_seconds = ELAPSED_MAX;
        end
        else
        begin
            rsp.elapsed_seconds = ELAPSED_WIDTH'(state_next.seconds_count);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sail_trim_motor_controller_top.sv @@
// top level of the sail trim motor controller
//
// The request channel (req_valid, req_stall, req) takes start and tick
// transactions; the response channel (rsp_valid, rsp_stall, rsp) returns
// exactly one result per request, in order. A transaction completes at a
// rising edge with valid high and stall low.
// A request is registered on acceptance, processed by one pass of compare
// and count logic against the trim state, and its result is registered:
// rsp_valid rises once the request moves from the input register into the
// result register, a move that waits while a stalled result is held;
// one request is taken every cycle when the receiver does not stall.
// When rsp_stall holds a waiting result, one further request is still
// taken into the input register; req_stall rises only while both registers
// are full and rsp_stall is high, and the trim state advances as each
// transaction passes into the result register.
// Reset clears the trim state (motor stopped, flags and counters zero),
// empties both registers and loads the register defaults. Configuration
// writes (cfg_we, cfg_index, cfg_data) take effect at the next edge; the
// user must make them only while no transaction is in flight (unchecked).
`default_nettype none

`include "sail_trim_motor_controller_top_defines.svh"

module sail_trim_motor_controller_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire stmc_pkg::stmc_in_t                   req,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output stmc_pkg::stmc_out_t                       rsp,
    input  wire logic                                 cfg_we,
    input  wire logic [stmc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [stmc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import stmc_pkg::*;

    stmc_cfg_t   cfg;
    stmc_state_t state_reg;
    stmc_state_t state_next;
    stmc_in_t    s1_item_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    stmc_out_t   rsp_reg;
    stmc_out_t   step_rsp;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        out_free;
    logic        s1_take;
    logic        s1_adv;

    stmc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stmc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (s1_item_reg),
        .state_next (state_next),
        .rsp        (step_rsp)
    );

    assign out_free       = !rsp_valid_reg || !rsp_stall;
    assign s1_adv         = s1_valid_reg && out_free;
    assign s1_take        = !s1_valid_reg || out_free;
    assign s1_valid_next  = s1_take ? req_valid : s1_valid_reg;
    assign rsp_valid_next = out_free ? s1_valid_reg : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_take && req_valid)
        begin
            s1_item_reg <= req;
        end
        if (s1_adv)
        begin
            rsp_reg <= step_rsp;
        end
    end

    assign req_stall = !s1_take;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `STMC_ASSERT_IMP(a_drive_exclusive, state_reg.drive_bits[0], !state_reg.drive_bits[1], "both motor inputs driven")
    `STMC_ASSERT_IMP(a_idle_stopped, !state_reg.active, state_reg.drive_bits == DRIVE_STOP, "motor driven while idle")
    `STMC_ASSERT_NXT(a_result_loaded, s1_adv, rsp_valid_reg, "processed transaction lost")
    `STMC_ASSERT_NXT(a_reject_holds, s1_adv && step_rsp.order_rejected, $stable(state_reg), "rejected order changed state")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// testbench for the sail trim motor controller: scoreboard, stimulus and checks
`timescale 1ns / 1ps

module tb;
    import stmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    class trim_scoreboard;
        stmc_cfg_t                limits;
        logic                     running;
        logic [ANGLE_WIDTH-1:0]   goal_angle;
        logic [ANGLE_WIDTH-1:0]   last_seen;
        logic [SAME_WIDTH-1:0]    still_secs;
        logic [SECONDS_WIDTH-1:0] trim_secs;
        logic                     timeout_seen;
        logic                     stall_seen;
        logic [1:0]               motor;
        stmc_out_t                expected_q[$];
        int                       errors;
        int                       orders;
        int                       ticks;
        int                       rejects;
        int                       finishes;
        int                       timeouts;
        int                       stalls;
        int                       checked;

        function new();
            limits       = CFG_RESET;
            running      = 1'b0;
            goal_angle   = '0;
            last_seen    = '0;
            still_secs   = '0;
            trim_secs    = '0;
            timeout_seen = 1'b0;
            stall_seen   = 1'b0;
            motor        = DRIVE_STOP;
            errors       = 0;
            orders       = 0;
            ticks        = 0;
            rejects      = 0;
            finishes     = 0;
            timeouts     = 0;
            stalls       = 0;
            checked      = 0;
        endfunction

        function void write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                     input logic [CFG_DATA_WIDTH-1:0] value);
            case (idx)
                CFG_IDX_DEADBAND:  limits.deadband         = value[DEADBAND_WIDTH-1:0];
                CFG_IDX_MAX_TRIM:  limits.max_trim_seconds = value[MAX_TRIM_WIDTH-1:0];
                CFG_IDX_STALL:     limits.stall_seconds    = value[STALL_WIDTH-1:0];
                CFG_IDX_MIN_ANGLE: limits.min_angle        = value[ANGLE_WIDTH-1:0];
                CFG_IDX_MAX_ANGLE: limits.max_angle        = value[ANGLE_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function logic [1:0] heading(input logic [ANGLE_WIDTH-1:0] pos,
                                     input logic [ANGLE_WIDTH-1:0] aim);
            if (pos > aim)
            begin
                return DRIVE_DOWN;
            end
            if (pos < aim)
            begin
                return DRIVE_UP;
            end
            return DRIVE_STOP;
        endfunction

        function void note_request(input stmc_in_t item);
            stmc_out_t res;
            logic      refused;
            logic      ended;
            logic      halt;
            int        gap;
            refused = 1'b0;
            ended   = 1'b0;
            halt    = 1'b0;
            if (item.cmd == CMD_START)
            begin
                orders++;
                if (item.target_angle < limits.min_angle ||
                    item.target_angle > limits.max_angle)
                begin
                    refused = 1'b1;
                    rejects++;
                end
                else
                begin
                    gap = int'(item.position) - int'(item.target_angle);
                    if (gap < 0)
                    begin
                        gap = -gap;
                    end
                    timeout_seen = 1'b0;
                    stall_seen   = 1'b0;
                    trim_secs    = '0;
                    still_secs   = '0;
                    last_seen    = item.position;
                    goal_angle   = item.target_angle;
                    running      = gap > int'(limits.deadband);
                    motor        = running ? heading(item.position, item.target_angle)
                                           : DRIVE_STOP;
                end
            end
            else
            begin
                ticks++;
                if (running)
                begin
                    if (trim_secs != SECONDS_MAX)
                    begin
                        trim_secs++;
                    end
                    if (trim_secs > limits.max_trim_seconds)
                    begin
                        halt         = 1'b1;
                        timeout_seen = 1'b1;
                    end
                    if (item.position == last_seen)
                    begin
                        if (still_secs != SAME_MAX)
                        begin
                            still_secs++;
                        end
                        if (still_secs > limits.stall_seconds)
                        begin
                            halt       = 1'b1;
                            stall_seen = 1'b1;
                        end
                    end
                    else
                    begin
                        last_seen  = item.position;
                        still_secs = '0;
                        stall_seen = 1'b0;
                    end
                    if (item.position == goal_angle)
                    begin
                        halt = 1'b1;
                    end
                    if (halt)
                    begin
                        running = 1'b0;
                        motor   = DRIVE_STOP;
                        ended   = 1'b1;
                        finishes++;
                        if (timeout_seen)
                        begin
                            timeouts++;
                        end
                        if (stall_seen)
                        begin
                            stalls++;
                        end
                    end
                    else
                    begin
                        motor = heading(item.position, goal_angle);
                    end
                end
            end
            res.drive_down      = (motor == DRIVE_DOWN);
            res.drive_up        = (motor == DRIVE_UP);
            res.trimming        = running;
            res.finished        = ended;
            res.timed_out       = timeout_seen;
            res.stalled         = stall_seen;
            res.order_rejected  = refused;
            res.elapsed_seconds = ELAPSED_WIDTH'(trim_secs);
            expected_q.push_back(res);
        endfunction

        function void compare_field(input string name,
                                    input logic [ELAPSED_WIDTH-1:0] want,
                                    input logic [ELAPSED_WIDTH-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(input stmc_out_t got);
            stmc_out_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("drive_down", ELAPSED_WIDTH'(want.drive_down),
                          ELAPSED_WIDTH'(got.drive_down));
            compare_field("drive_up", ELAPSED_WIDTH'(want.drive_up),
                          ELAPSED_WIDTH'(got.drive_up));
            compare_field("trimming", ELAPSED_WIDTH'(want.trimming),
                          ELAPSED_WIDTH'(got.trimming));
            compare_field("finished", ELAPSED_WIDTH'(want.finished),
                          ELAPSED_WIDTH'(got.finished));
            compare_field("timed_out", ELAPSED_WIDTH'(want.timed_out),
                          ELAPSED_WIDTH'(got.timed_out));
            compare_field("stalled", ELAPSED_WIDTH'(want.stalled),
                          ELAPSED_WIDTH'(got.stalled));
            compare_field("order_rejected", ELAPSED_WIDTH'(want.order_rejected),
                          ELAPSED_WIDTH'(got.order_rejected));
            compare_field("elapsed_seconds", want.elapsed_seconds, got.elapsed_seconds);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    stmc_in_t                   req       = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    stmc_out_t                  rsp;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    trim_scoreboard sb;
    bit             steady = 1'b0;
    int             sent_total = 0;
    int             quiet_cycles = 0;
    int             settings_used = 1;

    sail_trim_motor_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_response(rsp);
            end
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sail_trim_motor_controller_top test failed");
                $finish;
            end
        end
        rsp_stall <= !steady && ($urandom_range(0, 99) < 10);
    end

    task automatic send_request(input stmc_in_t item);
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(item);
        sent_total++;
    endtask

    task automatic push_item(input logic cmd, input int aim, input int pos);
        stmc_in_t item;
        item.cmd          = cmd;
        item.target_angle = ANGLE_WIDTH'(aim);
        item.position     = ANGLE_WIDTH'(pos);
        send_request(item);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_register(idx, value);
    endtask

    task automatic apply_settings(input stmc_cfg_t s);
        cfg_we <= 1'b1;
        put_reg(CFG_IDX_DEADBAND, CFG_DATA_WIDTH'(s.deadband));
        put_reg(CFG_IDX_MAX_TRIM, CFG_DATA_WIDTH'(s.max_trim_seconds));
        put_reg(CFG_IDX_STALL, CFG_DATA_WIDTH'(s.stall_seconds));
        put_reg(CFG_IDX_MIN_ANGLE, CFG_DATA_WIDTH'(s.min_angle));
        put_reg(CFG_IDX_MAX_ANGLE, CFG_DATA_WIDTH'(s.max_angle));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic stmc_cfg_t make_settings(input int db, input int mt, input int st,
                                                input int lo, input int hi);
        stmc_cfg_t s;
        s.deadband         = DEADBAND_WIDTH'(db);
        s.max_trim_seconds = MAX_TRIM_WIDTH'(mt);
        s.stall_seconds    = STALL_WIDTH'(st);
        s.min_angle        = ANGLE_WIDTH'(lo);
        s.max_angle        = ANGLE_WIDTH'(hi);
        return s;
    endfunction

    task automatic run_trim();
        int aim;
        int spot;
        int stride;
        int span;
        int hold_pct;
        int r;
        if (sb.limits.min_angle <= sb.limits.max_angle)
        begin
            aim = $urandom_range(int'(sb.limits.max_angle), int'(sb.limits.min_angle));
        end
        else
        begin
            aim = $urandom_range(0, 511);
        end
        if ($urandom_range(0, 99) < 70)
        begin
            spot = aim + $urandom_range(0, 240) - 120;
            spot = (spot < 0) ? 0 : (spot > 511) ? 511 : spot;
        end
        else
        begin
            spot = $urandom_range(0, 511);
        end
        stride   = $urandom_range(1, 30);
        span     = $urandom_range(1, 40);
        hold_pct = ($urandom_range(0, 99) < 15) ? 70 : 15;
        push_item(CMD_START, aim, spot);
        repeat (span)
        begin
            r = $urandom_range(0, 99);
            if (r < hold_pct)
            begin
                spot = spot;
            end
            else if (r < hold_pct + 5)
            begin
                spot = $urandom_range(0, 511);
            end
            else if (spot < aim)
            begin
                spot = (spot + stride > aim) ? aim : spot + stride;
            end
            else if (spot > aim)
            begin
                spot = (spot - stride < aim) ? aim : spot - stride;
            end
            push_item(CMD_TICK, $urandom_range(0, 511), spot);
        end
    endtask

    task automatic run_traffic(input int budget);
        int goal_count;
        goal_count = sent_total + budget;
        while (sent_total < goal_count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                run_trim();
            end
            else
            begin
                push_item(1'($urandom_range(0, 1)), $urandom_range(0, 511),
                          $urandom_range(0, 511));
            end
        end
    endtask

    task automatic run_directed();
        push_item(CMD_TICK, 0, 0);
        push_item(CMD_START, 9, 0);
        push_item(CMD_START, 511, 511);
        push_item(CMD_START, 10, 10);
        push_item(CMD_START, 500, 0);
        push_item(CMD_START, 505, 7);
        push_item(CMD_TICK, 0, 0);
        push_item(CMD_TICK, 0, 0);
        push_item(CMD_TICK, 0, 511);
        push_item(CMD_START, 20, 511);
        push_item(CMD_TICK, 0, 400);
        push_item(CMD_TICK, 0, 300);
        push_item(CMD_TICK, 0, 200);
        push_item(CMD_TICK, 0, 100);
        push_item(CMD_START, 30, 40);
        push_item(CMD_START, 200, 40);
        push_item(CMD_TICK, 0, 200);
        // timeout and stall land on the same tick
        push_item(CMD_START, 100, 50);
        push_item(CMD_TICK, 0, 60);
        push_item(CMD_TICK, 0, 70);
        push_item(CMD_TICK, 0, 70);
        push_item(CMD_TICK, 0, 70);
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_traffic(130);
        drain();

        apply_settings(make_settings(0, 3, 1, 10, 500));
        run_directed();
        run_traffic(100);
        drain();

        steady = 1'b1;
        apply_settings(make_settings(255, 0, 0, 0, 511));
        run_traffic(100);
        drain();

        // unchanged-position count runs into saturation
        apply_settings(make_settings(0, 4095, 255, 0, 511));
        push_item(CMD_START, 511, 0);
        repeat (300) push_item(CMD_TICK, 0, 0);
        run_traffic(50);
        drain();
        steady = 1'b0;

        apply_settings(make_settings(0, 4095, 255, 511, 0));
        run_traffic(30);
        drain();

        repeat (3)
        begin
            apply_settings(make_settings($urandom_range(0, 20), $urandom_range(5, 60),
                                         $urandom_range(1, 8), $urandom_range(0, 100),
                                         $urandom_range(260, 511)));
            run_traffic(120);
            drain();
        end

        $display("covered %0d starts (%0d refused) and %0d ticks under %0d register settings",
                 sb.orders, sb.rejects, sb.ticks, settings_used);
        $display("%0d trims ended, %0d on timeout, %0d on stall; %0d results compared",
                 sb.finishes, sb.timeouts, sb.stalls, sb.checked);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("sail_trim_motor_controller_top test passed");
        end
        else
        begin
            $display("sail_trim_motor_controller_top test failed");
        end
        $finish;
    end
endmodule
